FILE: hw/rtl/lli_pkg.sv
// Shared types and status codes for the line intersection block.
package lli_pkg;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_PAR = 2'd1,
    ST_SAT = 2'd2
  } status_e;

endpackage

FILE: hw/rtl/line_line_intersection.sv
// Pipelined intersection of two infinite lines by the determinant formula.
//
// Usage: each slave word carries two lines, two points each, as eight signed
// Q8.8 coordinates (x1,y1,x2,y2,x3,y3,x4,y4, lowest bits first). Each master
// word returns the crossing point in signed Q16.16 on tdata and a status on
// tuser: ok, parallel (zero denominator, coordinates zero) or saturated.
// Throughput is one word per cycle while the receiver does not stall. NSW
// is the numerator width fed to the divider (59 at the default widths):
// five stages form the differences, the cross products and the numerators,
// then a restoring divider resolves one quotient bit per stage, and a
// final stage clamps and registers the result.
// Every stage has its own valid bit. When the receiver stalls, words pile
// up towards the input and bubbles are squeezed out; tready at the slave
// side drops only when every stage holds a word. Nothing is lost or
// repeated. Reset clears all valid bits; the data registers are not reset.
module line_line_intersection #(
  parameter int COORD_WIDTH = 16,
  parameter int OUT_WIDTH   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // line_a_p1_x, line_a_p1_y, line_a_p2_x, line_a_p2_y,
  // line_b_p1_x, line_b_p1_y, line_b_p2_x, line_b_p2_y
  input  logic [8*COORD_WIDTH-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // cross_x, cross_y
  output logic [2*OUT_WIDTH-1:0]     m_axis_tdata,
  // status
  output lli_pkg::status_e           m_axis_tuser
);
  import lli_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int OW   = OUT_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int DENW = PW + 1;
  localparam int CAW  = 2 * CW + 1;
  localparam int NW   = CAW + DW + 1;
  localparam int SH   = OW / 2 - CW / 2;
  localparam int SHN  = (SH > 0) ? SH : 0;
  localparam int SHD  = (SH < 0) ? -SH : 0;
  localparam int NSW  = NW + SHN;
  localparam int DSW  = DENW + SHD;
  localparam int EW   = ((NSW > OW) ? NSW : OW) + 1;

  // Coordinates unpacked from the slave word.
  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = s_axis_tdata[0*CW +: CW];
  assign y1 = s_axis_tdata[1*CW +: CW];
  assign x2 = s_axis_tdata[2*CW +: CW];
  assign y2 = s_axis_tdata[3*CW +: CW];
  assign x3 = s_axis_tdata[4*CW +: CW];
  assign y3 = s_axis_tdata[5*CW +: CW];
  assign x4 = s_axis_tdata[6*CW +: CW];
  assign y4 = s_axis_tdata[7*CW +: CW];

  logic [5:1] v_q;
  logic [5:1] g;
  logic [NSW-1:0] dv_q;
  logic [NSW-1:0] gd;
  logic vo_q;
  logic go;

  // Stage advance chain from the output back to the input.
  always_comb begin
    go = !vo_q || m_axis_tready;
    gd[NSW-1] = !dv_q[NSW-1] || go;
    for (int k = NSW - 2; k >= 0; k--) begin
      gd[k] = !dv_q[k] || gd[k+1];
    end
    g[5] = !v_q[5] || gd[0];
    for (int k = 4; k >= 1; k--) begin
      g[k] = !v_q[k] || g[k+1];
    end
  end
  assign s_axis_tready = g[1];

  // Stage 1: point differences, coordinates kept for the cross products.
  logic signed [DW-1:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  always_ff @(posedge clk_i) begin
    if (g[1]) begin
      dxa_q <= DW'(x1) - DW'(x2);
      dya_q <= DW'(y1) - DW'(y2);
      dxb_q <= DW'(x3) - DW'(x4);
      dyb_q <= DW'(y3) - DW'(y4);
      x1_q <= x1; y1_q <= y1; x2_q <= x2; y2_q <= y2;
      x3_q <= x3; y3_q <= y3; x4_q <= x4; y4_q <= y4;
    end
  end

  // Stage 2: the six first-level products.
  logic signed [PW-1:0]    pd1_q, pd2_q;
  logic signed [2*CW-1:0]  pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [DW-1:0]    dxa2_q, dya2_q, dxb2_q, dyb2_q;
  always_ff @(posedge clk_i) begin
    if (g[2]) begin
      pd1_q <= PW'(dxa_q) * PW'(dyb_q);
      pd2_q <= PW'(dya_q) * PW'(dxb_q);
      pa1_q <= (2*CW)'(x1_q) * (2*CW)'(y2_q);
      pa2_q <= (2*CW)'(y1_q) * (2*CW)'(x2_q);
      pb1_q <= (2*CW)'(x3_q) * (2*CW)'(y4_q);
      pb2_q <= (2*CW)'(y3_q) * (2*CW)'(x4_q);
      dxa2_q <= dxa_q; dya2_q <= dya_q; dxb2_q <= dxb_q; dyb2_q <= dyb_q;
    end
  end

  // Stage 3: denominator and the two line constants.
  logic signed [DENW-1:0] den3_q;
  logic signed [CAW-1:0]  ca_q, cb_q;
  logic signed [DW-1:0]   dxa3_q, dya3_q, dxb3_q, dyb3_q;
  always_ff @(posedge clk_i) begin
    if (g[3]) begin
      den3_q <= DENW'(pd1_q) - DENW'(pd2_q);
      ca_q   <= CAW'(pa1_q) - CAW'(pa2_q);
      cb_q   <= CAW'(pb1_q) - CAW'(pb2_q);
      dxa3_q <= dxa2_q; dya3_q <= dya2_q; dxb3_q <= dxb2_q; dyb3_q <= dyb2_q;
    end
  end

  // Stage 4: the four numerator products.
  logic signed [NW-2:0]   m1_q, m2_q, m3_q, m4_q;
  logic signed [DENW-1:0] den4_q;
  always_ff @(posedge clk_i) begin
    if (g[4]) begin
      m1_q <= (NW-1)'(ca_q) * (NW-1)'(dxb3_q);
      m2_q <= (NW-1)'(dxa3_q) * (NW-1)'(cb_q);
      m3_q <= (NW-1)'(ca_q) * (NW-1)'(dyb3_q);
      m4_q <= (NW-1)'(dya3_q) * (NW-1)'(cb_q);
      den4_q <= den3_q;
    end
  end

  // Stage 5: numerators, scaling, magnitudes and signs for the divider.
  logic signed [NW-1:0]  nx, ny;
  logic signed [NSW-1:0] nxs, nys;
  logic signed [DSW-1:0] dens;
  assign nx   = NW'(m1_q) - NW'(m2_q);
  assign ny   = NW'(m3_q) - NW'(m4_q);
  assign nxs  = NSW'(nx) <<< SHN;
  assign nys  = NSW'(ny) <<< SHN;
  assign dens = DSW'(den4_q) <<< SHD;

  logic [NSW-1:0] ax5_q, ay5_q;
  logic [DSW-1:0] ad5_q;
  logic           negx5_q, negy5_q, zero5_q;
  always_ff @(posedge clk_i) begin
    if (g[5]) begin
      ax5_q   <= nxs[NSW-1] ? NSW'(-nxs) : NSW'(nxs);
      ay5_q   <= nys[NSW-1] ? NSW'(-nys) : NSW'(nys);
      ad5_q   <= dens[DSW-1] ? DSW'(-dens) : DSW'(dens);
      negx5_q <= nxs[NSW-1] ^ dens[DSW-1];
      negy5_q <= nys[NSW-1] ^ dens[DSW-1];
      zero5_q <= (den4_q == '0);
    end
  end

  // Restoring divider: one quotient bit per stage, shifted into the numerator.
  logic [NSW-1:0] nxd_q [NSW];
  logic [NSW-1:0] nyd_q [NSW];
  logic [DSW-1:0] rx_q  [NSW];
  logic [DSW-1:0] ry_q  [NSW];
  logic [DSW-1:0] dd_q  [NSW];
  logic           negx_q [NSW];
  logic           negy_q [NSW];
  logic           zero_q [NSW];

  for (genvar k = 0; k < NSW; k++) begin : g_div
    logic [NSW-1:0] nxi, nyi;
    logic [DSW-1:0] rxi, ryi, ddi;
    logic           nxgi, nygi, zi;
    logic [DSW:0]   tx, ty;
    logic           gex, gey;
    if (k == 0) begin : g_first
      assign nxi = ax5_q;  assign nyi = ay5_q;
      assign rxi = '0;     assign ryi = '0;
      assign ddi = ad5_q;
      assign nxgi = negx5_q; assign nygi = negy5_q; assign zi = zero5_q;
    end else begin : g_next
      assign nxi = nxd_q[k-1]; assign nyi = nyd_q[k-1];
      assign rxi = rx_q[k-1];  assign ryi = ry_q[k-1];
      assign ddi = dd_q[k-1];
      assign nxgi = negx_q[k-1]; assign nygi = negy_q[k-1]; assign zi = zero_q[k-1];
    end
    assign tx  = {rxi, nxi[NSW-1]};
    assign ty  = {ryi, nyi[NSW-1]};
    assign gex = (tx >= {1'b0, ddi});
    assign gey = (ty >= {1'b0, ddi});
    always_ff @(posedge clk_i) begin
      if (gd[k]) begin
        rx_q[k]   <= gex ? DSW'(tx - {1'b0, ddi}) : DSW'(tx);
        ry_q[k]   <= gey ? DSW'(ty - {1'b0, ddi}) : DSW'(ty);
        nxd_q[k]  <= {nxi[NSW-2:0], gex};
        nyd_q[k]  <= {nyi[NSW-2:0], gey};
        dd_q[k]   <= ddi;
        negx_q[k] <= nxgi;
        negy_q[k] <= nygi;
        zero_q[k] <= zi;
      end
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      dv_q <= '0;
      vo_q <= 1'b0;
    end else begin
      if (g[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= 5; k++) begin
        if (g[k]) v_q[k] <= v_q[k-1];
      end
      if (gd[0]) dv_q[0] <= v_q[5];
      for (int k = 1; k < NSW; k++) begin
        if (gd[k]) dv_q[k] <= dv_q[k-1];
      end
      if (go) vo_q <= dv_q[NSW-1];
    end
  end

  // Final stage: sign, clamp and status.
  localparam logic [EW-1:0] MaxPos = (EW'(1) << (OW - 1)) - EW'(1);
  logic [EW-1:0]  qx, qy;
  logic [OW-1:0]  rxo, ryo;
  logic           satx, saty;
  always_comb begin
    qx = EW'(nxd_q[NSW-1]);
    qy = EW'(nyd_q[NSW-1]);
    if (!negx_q[NSW-1]) begin
      satx = (qx > MaxPos);
      rxo  = satx ? OW'(MaxPos) : OW'(qx);
    end else begin
      satx = (qx > MaxPos + EW'(1));
      rxo  = satx ? ~OW'(MaxPos) : OW'(-qx);
    end
    if (!negy_q[NSW-1]) begin
      saty = (qy > MaxPos);
      ryo  = saty ? OW'(MaxPos) : OW'(qy);
    end else begin
      saty = (qy > MaxPos + EW'(1));
      ryo  = saty ? ~OW'(MaxPos) : OW'(-qy);
    end
  end

  logic [OW-1:0] ox_q, oy_q;
  status_e       ost_q;
  always_ff @(posedge clk_i) begin
    if (go) begin
      if (zero_q[NSW-1]) begin
        ox_q  <= '0;
        oy_q  <= '0;
        ost_q <= ST_PAR;
      end else begin
        ox_q  <= rxo;
        oy_q  <= ryo;
        ost_q <= (satx || saty) ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {oy_q, ox_q};
  assign m_axis_tuser  = ost_q;

  // A parallel result always carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && ost_q == ST_PAR) |-> (ox_q == '0 && oy_q == '0))
    else $error("parallel result with nonzero coordinates");

  // Backpressure reaches the input only when every stage is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v_q == '1 && dv_q == '1 && vo_q))
    else $error("input stalled with an empty stage");

  // A held result is not overwritten while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !m_axis_tready) |=> (vo_q && $stable(ox_q) && $stable(oy_q)))
    else $error("stalled result changed");

  // A valid result always carries one of the three defined status codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (ost_q == ST_OK || ost_q == ST_PAR || ost_q == ST_SAT))
    else $error("undefined status code");

endmodule
